// ===== hdl/cmfuv_pkg.sv =====
// Shared face codes and pipeline sideband type for the cube map face unit.
package cmfuv_pkg;

    typedef logic [2:0] face_t;

    localparam face_t FACE_PX = 3'd0;
    localparam face_t FACE_NX = 3'd1;
    localparam face_t FACE_PY = 3'd2;
    localparam face_t FACE_NY = 3'd3;
    localparam face_t FACE_PZ = 3'd4;
    localparam face_t FACE_NZ = 3'd5;

    typedef struct packed {
        logic  valid;
        logic  zero;
        face_t face;
    } side_t;

endpackage

// ===== hdl/cubemap_direction_to_face_uv_top.sv =====
// Top level of the cube map face selection pipeline.
//
// Usage:
//   A beat enters when start is high and busy is low. busy is never raised,
//   so one direction (dir_x, dir_y, dir_z, two's complement) may enter every
//   cycle. Each beat produces exactly one result, shown for one cycle with
//   done high: face (0 +X .. 5 -Z), tex_u, tex_v and zero_vector.
//   The pipe holds two front-end stages, one integer-quotient stage,
//   FRAC_BITS - 1 restoring divider stages producing one quotient bit
//   each, and the output register. Throughput is one beat per cycle,
//   set by the fully pipelined divider.
//   Results leave in the order their beats entered.
//   The receiver cannot hold results off; none is needed as nothing stalls.
//   Reset clears all valid bits, so no result appears until a beat has
//   passed the whole pipe. An all-zero direction gives face +X, zero
//   coordinates and zero_vector high.
module cubemap_direction_to_face_uv_top #(
    parameter int COMP_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COMP_BITS-1:0]  dir_x,
    input  logic [COMP_BITS-1:0]  dir_y,
    input  logic [COMP_BITS-1:0]  dir_z,
    output logic                  done,
    output logic [2:0]            face,
    output logic [FRAC_BITS-1:0]  tex_u,
    output logic [FRAC_BITS-1:0]  tex_v,
    output logic                  zero_vector
);

    localparam int LATENCY = FRAC_BITS + 3;

    cmfuv_pkg::side_t     sel_sb, div_sb;
    logic [COMP_BITS-1:0] sel_major;
    logic [COMP_BITS:0]   sel_num_u, sel_num_v;
    logic [FRAC_BITS:0]   q_u, q_v;

    logic                 done_reg;
    cmfuv_pkg::face_t     face_reg, face_next;
    logic [FRAC_BITS-1:0] tex_u_reg, tex_u_next;
    logic [FRAC_BITS-1:0] tex_v_reg, tex_v_next;
    logic                 zero_reg;

    assign busy = 1'b0;

    cmfuv_select #(
        .COMP_BITS (COMP_BITS)
    ) u_select (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start & ~busy),
        .dir_x    (dir_x),
        .dir_y    (dir_y),
        .dir_z    (dir_z),
        .sb       (sel_sb),
        .major    (sel_major),
        .num_u    (sel_num_u),
        .num_v    (sel_num_v)
    );

    cmfuv_div #(
        .COMP_BITS (COMP_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .sb_in    (sel_sb),
        .major_in (sel_major),
        .num_u_in (sel_num_u),
        .num_v_in (sel_num_v),
        .sb_out   (div_sb),
        .q_u      (q_u),
        .q_v      (q_v)
    );

    // quotient of 2^FRAC_BITS saturates; zero vector overrides everything
    always_comb
    begin
        if (div_sb.zero)
        begin
            face_next  = cmfuv_pkg::FACE_PX;
            tex_u_next = '0;
            tex_v_next = '0;
        end
        else
        begin
            face_next  = div_sb.face;
            tex_u_next = q_u[FRAC_BITS] ? '1 : q_u[FRAC_BITS-1:0];
            tex_v_next = q_v[FRAC_BITS] ? '1 : q_v[FRAC_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_sb.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        face_reg  <= face_next;
        tex_u_reg <= tex_u_next;
        tex_v_reg <= tex_v_next;
        zero_reg  <= div_sb.zero;
    end

    assign done        = done_reg;
    assign face        = face_reg;
    assign tex_u       = tex_u_reg;
    assign tex_v       = tex_v_reg;
    assign zero_vector = zero_reg;

    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted beat did not produce a result");

    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without an accepted beat");

    a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (face <= cmfuv_pkg::FACE_NZ))
        else $error("face code out of range");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && zero_vector) |->
            (face == cmfuv_pkg::FACE_PX && tex_u == '0 && tex_v == '0))
        else $error("zero vector result not cleared");

endmodule

// ===== hdl/cmfuv_select.sv =====
// Two-stage front end: magnitudes, major axis choice, face and numerators.
module cmfuv_select #(
    parameter int COMP_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [COMP_BITS-1:0]    dir_x,
    input  logic [COMP_BITS-1:0]    dir_y,
    input  logic [COMP_BITS-1:0]    dir_z,
    output cmfuv_pkg::side_t        sb,
    output logic [COMP_BITS-1:0]    major,
    output logic [COMP_BITS:0]      num_u,
    output logic [COMP_BITS:0]      num_v
);

    // stage 1: components and magnitudes
    logic                        v1_reg;
    logic signed [COMP_BITS-1:0] x1_reg, y1_reg, z1_reg;
    logic [COMP_BITS-1:0]        ax1_reg, ay1_reg, az1_reg;
    logic [COMP_BITS-1:0]        ax_next, ay_next, az_next;

    // stage 2: face, major and numerators
    cmfuv_pkg::side_t            sb_reg, sb_next;
    logic [COMP_BITS-1:0]        major_reg, major_next;
    logic [COMP_BITS:0]          num_u_reg, num_u_next;
    logic [COMP_BITS:0]          num_v_reg, num_v_next;

    logic signed [COMP_BITS:0]   xe, ye, ze, mu, mv;
    logic signed [COMP_BITS+1:0] sum_u, sum_v;

    assign ax_next = dir_x[COMP_BITS-1] ? (~dir_x + 1'b1) : dir_x;
    assign ay_next = dir_y[COMP_BITS-1] ? (~dir_y + 1'b1) : dir_y;
    assign az_next = dir_z[COMP_BITS-1] ? (~dir_z + 1'b1) : dir_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg  <= dir_x;
        y1_reg  <= dir_y;
        z1_reg  <= dir_z;
        ax1_reg <= ax_next;
        ay1_reg <= ay_next;
        az1_reg <= az_next;
    end

    assign xe = {x1_reg[COMP_BITS-1], x1_reg};
    assign ye = {y1_reg[COMP_BITS-1], y1_reg};
    assign ze = {z1_reg[COMP_BITS-1], z1_reg};

    always_comb
    begin
        sb_next.valid = v1_reg;
        sb_next.zero  = ((ax1_reg | ay1_reg | az1_reg) == '0);
        if (az1_reg >= ax1_reg && az1_reg >= ay1_reg)
        begin
            sb_next.face = z1_reg[COMP_BITS-1] ? cmfuv_pkg::FACE_NZ : cmfuv_pkg::FACE_PZ;
            major_next   = az1_reg;
            mu           = z1_reg[COMP_BITS-1] ? -xe : xe;
            mv           = -ye;
        end
        else if (ay1_reg >= ax1_reg)
        begin
            sb_next.face = y1_reg[COMP_BITS-1] ? cmfuv_pkg::FACE_NY : cmfuv_pkg::FACE_PY;
            major_next   = ay1_reg;
            mu           = xe;
            mv           = y1_reg[COMP_BITS-1] ? -ze : ze;
        end
        else
        begin
            sb_next.face = x1_reg[COMP_BITS-1] ? cmfuv_pkg::FACE_NX : cmfuv_pkg::FACE_PX;
            major_next   = ax1_reg;
            mu           = x1_reg[COMP_BITS-1] ? ze : -ze;
            mv           = -ye;
        end
        sum_u      = $signed({2'b00, major_next}) + $signed({mu[COMP_BITS], mu});
        sum_v      = $signed({2'b00, major_next}) + $signed({mv[COMP_BITS], mv});
        num_u_next = sum_u[COMP_BITS:0];
        num_v_next = sum_v[COMP_BITS:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sb_reg <= '0;
        end
        else
        begin
            sb_reg <= sb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        major_reg <= major_next;
        num_u_reg <= num_u_next;
        num_v_reg <= num_v_next;
    end

    assign sb    = sb_reg;
    assign major = major_reg;
    assign num_u = num_u_reg;
    assign num_v = num_v_reg;

endmodule

// ===== hdl/cmfuv_div_step.sv =====
// One restoring division stage: one quotient bit per lane, two lanes.
module cmfuv_div_step #(
    parameter int COMP_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmfuv_pkg::side_t        sb_i,
    input  logic [COMP_BITS-1:0]    major_i,
    input  logic [COMP_BITS-1:0]    r_u_i,
    input  logic [COMP_BITS-1:0]    r_v_i,
    input  logic [FRAC_BITS:0]      q_u_i,
    input  logic [FRAC_BITS:0]      q_v_i,
    output cmfuv_pkg::side_t        sb_o,
    output logic [COMP_BITS-1:0]    major_o,
    output logic [COMP_BITS-1:0]    r_u_o,
    output logic [COMP_BITS-1:0]    r_v_o,
    output logic [FRAC_BITS:0]      q_u_o,
    output logic [FRAC_BITS:0]      q_v_o
);

    cmfuv_pkg::side_t     sb_reg;
    logic [COMP_BITS-1:0] major_reg;
    logic [COMP_BITS-1:0] r_u_reg, r_u_next, r_v_reg, r_v_next;
    logic [FRAC_BITS:0]   q_u_reg, q_u_next, q_v_reg, q_v_next;
    logic [COMP_BITS:0]   r2_u, r2_v, d_u, d_v;
    logic                 ge_u, ge_v;

    // remainder stays below major, so the shifted value fits one extra bit
    assign r2_u = {r_u_i, 1'b0};
    assign r2_v = {r_v_i, 1'b0};
    assign ge_u = (r2_u >= {1'b0, major_i});
    assign ge_v = (r2_v >= {1'b0, major_i});
    assign d_u  = ge_u ? (r2_u - {1'b0, major_i}) : r2_u;
    assign d_v  = ge_v ? (r2_v - {1'b0, major_i}) : r2_v;

    assign r_u_next = d_u[COMP_BITS-1:0];
    assign r_v_next = d_v[COMP_BITS-1:0];
    assign q_u_next = {q_u_i[FRAC_BITS-1:0], ge_u};
    assign q_v_next = {q_v_i[FRAC_BITS-1:0], ge_v};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sb_reg <= '0;
        end
        else
        begin
            sb_reg <= sb_i;
        end
    end

    always_ff @(posedge clk)
    begin
        major_reg <= major_i;
        r_u_reg   <= r_u_next;
        r_v_reg   <= r_v_next;
        q_u_reg   <= q_u_next;
        q_v_reg   <= q_v_next;
    end

    assign sb_o    = sb_reg;
    assign major_o = major_reg;
    assign r_u_o   = r_u_reg;
    assign r_v_o   = r_v_reg;
    assign q_u_o   = q_u_reg;
    assign q_v_o   = q_v_reg;

endmodule

// ===== hdl/cmfuv_div.sv =====
// Pipelined two-lane divider: integer part stage then one stage per fraction bit.
module cmfuv_div #(
    parameter int COMP_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmfuv_pkg::side_t        sb_in,
    input  logic [COMP_BITS-1:0]    major_in,
    input  logic [COMP_BITS:0]      num_u_in,
    input  logic [COMP_BITS:0]      num_v_in,
    output cmfuv_pkg::side_t        sb_out,
    output logic [FRAC_BITS:0]      q_u,
    output logic [FRAC_BITS:0]      q_v
);

    localparam int STEPS = FRAC_BITS - 1;

    cmfuv_pkg::side_t     sb_s    [0:STEPS];
    logic [COMP_BITS-1:0] major_s [0:STEPS];
    logic [COMP_BITS-1:0] r_u_s   [0:STEPS];
    logic [COMP_BITS-1:0] r_v_s   [0:STEPS];
    logic [FRAC_BITS:0]   q_u_s   [0:STEPS];
    logic [FRAC_BITS:0]   q_v_s   [0:STEPS];

    cmfuv_pkg::side_t     sb_reg;
    logic [COMP_BITS-1:0] major_reg;
    logic [COMP_BITS-1:0] r_u_reg, r_v_reg;
    logic [1:0]           qi_u_reg, qi_v_reg;
    logic [COMP_BITS+1:0] ip_u, ip_v;

    // integer part of num/major is 0, 1 or 2; returns {quotient, remainder}
    function automatic logic [COMP_BITS+1:0] int_part(
        input logic [COMP_BITS:0]   num,
        input logic [COMP_BITS-1:0] maj
    );
        logic [COMP_BITS+1:0] two_m;
        logic [COMP_BITS+1:0] n_ext;
        logic [COMP_BITS+1:0] d;
        logic [1:0]           q;
        two_m = {1'b0, maj, 1'b0};
        n_ext = {1'b0, num};
        if (n_ext >= two_m)
        begin
            q = 2'd2;
            d = n_ext - two_m;
        end
        else if (n_ext >= {2'b00, maj})
        begin
            q = 2'd1;
            d = n_ext - {2'b00, maj};
        end
        else
        begin
            q = 2'd0;
            d = n_ext;
        end
        return {q, d[COMP_BITS-1:0]};
    endfunction

    assign ip_u = int_part(num_u_in, major_in);
    assign ip_v = int_part(num_v_in, major_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sb_reg <= '0;
        end
        else
        begin
            sb_reg <= sb_in;
        end
    end

    always_ff @(posedge clk)
    begin
        major_reg <= major_in;
        qi_u_reg  <= ip_u[COMP_BITS+1:COMP_BITS];
        qi_v_reg  <= ip_v[COMP_BITS+1:COMP_BITS];
        r_u_reg   <= ip_u[COMP_BITS-1:0];
        r_v_reg   <= ip_v[COMP_BITS-1:0];
    end

    assign sb_s[0]    = sb_reg;
    assign major_s[0] = major_reg;
    assign r_u_s[0]   = r_u_reg;
    assign r_v_s[0]   = r_v_reg;
    assign q_u_s[0]   = {{(FRAC_BITS-1){1'b0}}, qi_u_reg};
    assign q_v_s[0]   = {{(FRAC_BITS-1){1'b0}}, qi_v_reg};

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        cmfuv_div_step #(
            .COMP_BITS (COMP_BITS),
            .FRAC_BITS (FRAC_BITS)
        ) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .sb_i    (sb_s[i]),
            .major_i (major_s[i]),
            .r_u_i   (r_u_s[i]),
            .r_v_i   (r_v_s[i]),
            .q_u_i   (q_u_s[i]),
            .q_v_i   (q_v_s[i]),
            .sb_o    (sb_s[i+1]),
            .major_o (major_s[i+1]),
            .r_u_o   (r_u_s[i+1]),
            .r_v_o   (r_v_s[i+1]),
            .q_u_o   (q_u_s[i+1]),
            .q_v_o   (q_v_s[i+1])
        );
    end

    assign sb_out = sb_s[STEPS];
    assign q_u    = q_u_s[STEPS];
    assign q_v    = q_v_s[STEPS];

endmodule
